[hw/rtl/pad_state_ring_writer_unit_assert.svh]
// ---------------------------------------------------------------------------
// pad state ring writer assertion macros
// shared concurrent assertion forms, clocked, with reset disable
// ---------------------------------------------------------------------------
`ifndef PAD_STATE_RING_WRITER_UNIT_ASSERT_SVH
`define PAD_STATE_RING_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prs assertion failed: same-cycle check");

// next-cycle implication
`define PRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prs assertion failed: next-cycle check");

`endif

[hw/rtl/prs_pkg.sv]
// ---------------------------------------------------------------------------
// prs_pkg
// shared widths, constants and types of the pad state ring writer
// ---------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

    // field widths
    localparam int BTN_W      = 15;
    localparam int STICK_W    = 9;
    localparam int TICK_W     = 63;
    localparam int WORD_W     = 32;
    localparam int SLOT_OUT_W = 3;
    localparam int THR_W      = 16;
    localparam int SQ_W       = 17;
    localparam int SUM_W      = SQ_W + 1;

    // stream widths
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 248;

    // direction bit positions in the pad word
    localparam int BIT_RIGHT = 28;
    localparam int BIT_LEFT  = 29;
    localparam int BIT_UP    = 30;
    localparam int BIT_DOWN  = 31;

    localparam logic [THR_W-1:0] THR_RESET = 16'd1600;

    localparam int RING_ENTRIES_DEFAULT = 8;
    localparam int QUEUE_DEPTH          = 2;

    // one unpacked sample with squared stick coordinates between front and back
    typedef struct packed {
        logic [BTN_W-1:0]          buttons;
        logic signed [STICK_W-1:0] x;
        logic signed [STICK_W-1:0] y;
        logic [TICK_W-1:0]         tick;
        logic [SQ_W-1:0]           xx;
        logic [SQ_W-1:0]           yy;
    } prs_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } prs_q_status_t;

endpackage

`default_nettype wire

[hw/rtl/prs_front.sv]
// ---------------------------------------------------------------------------
// prs_front
// accepts pad samples, unpacks them and squares the stick coordinates
// ---------------------------------------------------------------------------
`default_nettype none

module prs_front
(
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [prs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire prs_pkg::prs_q_status_t          q_status,
    output logic                                 push,
    output prs_pkg::prs_entry_t                  push_entry
);

    logic signed [prs_pkg::STICK_W-1:0]  x;
    logic signed [prs_pkg::STICK_W-1:0]  y;
    logic signed [prs_pkg::SUM_W-1:0]    x_ext;
    logic signed [prs_pkg::SUM_W-1:0]    y_ext;
    logic signed [prs_pkg::SUM_W-1:0]    x_sq;
    logic signed [prs_pkg::SUM_W-1:0]    y_sq;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    assign x = signed'(s_tdata[23:15]);
    assign y = signed'(s_tdata[32:24]);

    // squares fit in 17 bits, the worst case being -256 squared
    assign x_ext = prs_pkg::SUM_W'(x);
    assign y_ext = prs_pkg::SUM_W'(y);
    assign x_sq  = x_ext * x_ext;
    assign y_sq  = y_ext * y_ext;

    always_comb
    begin
        push_entry.buttons = s_tdata[14:0];
        push_entry.x       = x;
        push_entry.y       = y;
        push_entry.tick    = s_tdata[95:33];
        push_entry.xx      = x_sq[prs_pkg::SQ_W-1:0];
        push_entry.yy      = y_sq[prs_pkg::SQ_W-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/prs_queue.sv]
// ---------------------------------------------------------------------------
// prs_queue
// short register queue between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module prs_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire prs_pkg::prs_entry_t    push_entry,
    input  wire logic                   pop,
    output prs_pkg::prs_entry_t         head_entry,
    output prs_pkg::prs_q_status_t      q_status
);

`include "pad_state_ring_writer_unit_assert.svh"

    localparam int DEPTH = prs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    prs_pkg::prs_entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry     = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);

    `PRS_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_status.full, !push)
    `PRS_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, q_status.empty, !pop)
    `PRS_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_FULL)

endmodule

`default_nettype wire

[hw/rtl/prs_back.sv]
// ---------------------------------------------------------------------------
// prs_back
// direction sectors, edge masks, ring slot and wrap ticks, output register
// ---------------------------------------------------------------------------
`default_nettype none

module prs_back
#(
    parameter int RING_ENTRIES = prs_pkg::RING_ENTRIES_DEFAULT
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [prs_pkg::THR_W-1:0]        threshold,
    input  wire prs_pkg::prs_entry_t              head_entry,
    input  wire prs_pkg::prs_q_status_t           q_status,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [prs_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                  m_tuser
);

`include "pad_state_ring_writer_unit_assert.svh"

    localparam int SLOT_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int EXT_W  = (SLOT_W > prs_pkg::SLOT_OUT_W) ? SLOT_W : prs_pkg::SLOT_OUT_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_ENTRIES - 1);

    // ring and history state
    logic [SLOT_W-1:0]               next_slot_reg;
    logic [SLOT_W-1:0]               next_slot_next;
    logic [prs_pkg::WORD_W-1:0]      last_word_reg;
    logic [prs_pkg::TICK_W-1:0]      latest_tick_reg;
    logic [prs_pkg::TICK_W-1:0]      earlier_tick_reg;

    // output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [prs_pkg::SLOT_OUT_W-1:0]  slot_out_reg;
    logic [prs_pkg::WORD_W-1:0]      word_out_reg;
    logic [prs_pkg::WORD_W-1:0]      pressed_out_reg;
    logic [prs_pkg::WORD_W-1:0]      released_out_reg;
    logic [prs_pkg::STICK_W-1:0]     x_out_reg;
    logic [prs_pkg::STICK_W-1:0]     y_out_reg;
    logic                            wrapped_out_reg;
    logic [prs_pkg::TICK_W-1:0]      tick_out_reg;
    logic [prs_pkg::TICK_W-1:0]      before_out_reg;

    logic [prs_pkg::SUM_W-1:0]       radius_sq;
    logic [prs_pkg::SUM_W-1:0]       xx_ext;
    logic [prs_pkg::SUM_W-1:0]       yy_ext;
    logic [prs_pkg::SUM_W-1:0]       xx_times3;
    logic [prs_pkg::SUM_W-1:0]       yy_times3;
    logic                            outside;
    logic                            dir_rl;
    logic                            dir_ud;
    logic [prs_pkg::WORD_W-1:0]      word;
    logic [EXT_W-1:0]                slot_ext;
    logic                            wrapped;

    assign pop = !q_status.empty && (!out_valid_reg || m_tready);

    // sector tests on exact squares
    assign xx_ext    = prs_pkg::SUM_W'(head_entry.xx);
    assign yy_ext    = prs_pkg::SUM_W'(head_entry.yy);
    assign radius_sq = xx_ext + yy_ext;
    assign xx_times3 = xx_ext + {head_entry.xx, 1'b0};
    assign yy_times3 = yy_ext + {head_entry.yy, 1'b0};
    assign outside   = radius_sq > prs_pkg::SUM_W'(threshold);
    assign dir_rl    = outside && (head_entry.x != '0) && (yy_ext < xx_times3);
    assign dir_ud    = outside && ((head_entry.x == '0) || (yy_times3 > xx_ext));

    always_comb
    begin
        word = prs_pkg::WORD_W'(head_entry.buttons);
        word[prs_pkg::BIT_RIGHT] = dir_rl && (head_entry.x > 0);
        word[prs_pkg::BIT_LEFT]  = dir_rl && !(head_entry.x > 0);
        word[prs_pkg::BIT_UP]    = dir_ud && (head_entry.y > 0);
        word[prs_pkg::BIT_DOWN]  = dir_ud && !(head_entry.y > 0);
    end

    assign slot_ext       = EXT_W'(next_slot_reg);
    assign wrapped        = (next_slot_reg == '0);
    assign next_slot_next = (next_slot_reg == SLOT_LAST) ? '0 : next_slot_reg + 1'b1;

    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            next_slot_reg    <= '0;
            last_word_reg    <= '0;
            latest_tick_reg  <= '0;
            earlier_tick_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                next_slot_reg <= next_slot_next;
                last_word_reg <= word;
                if (wrapped)
                begin
                    latest_tick_reg  <= head_entry.tick;
                    earlier_tick_reg <= latest_tick_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot_out_reg     <= slot_ext[prs_pkg::SLOT_OUT_W-1:0];
            word_out_reg     <= word;
            pressed_out_reg  <= word & ~last_word_reg;
            released_out_reg <= last_word_reg & ~word;
            x_out_reg        <= head_entry.x;
            y_out_reg        <= head_entry.y;
            wrapped_out_reg  <= wrapped;
            tick_out_reg     <= wrapped ? head_entry.tick : latest_tick_reg;
            before_out_reg   <= wrapped ? latest_tick_reg : earlier_tick_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = wrapped_out_reg;
    assign m_tdata  = {5'b0, before_out_reg, tick_out_reg, y_out_reg, x_out_reg,
                       released_out_reg, pressed_out_reg, word_out_reg, slot_out_reg};

    `PRS_ASSERT_NOW(a_slot_in_ring, clk, rst_n, 1'b1, 32'(next_slot_reg) < RING_ENTRIES)
    `PRS_ASSERT_NEXT(a_slot_wraps, clk, rst_n, pop && (next_slot_reg == SLOT_LAST),
                     next_slot_reg == '0)
    `PRS_ASSERT_NEXT(a_wrap_latches_tick, clk, rst_n, pop && wrapped,
                     latest_tick_reg == tick_out_reg)

endmodule

`default_nettype wire

[hw/rtl/pad_state_ring_writer_unit.sv]
// ---------------------------------------------------------------------------
// pad_state_ring_writer_unit
// pad sample to ring entry writer with stick sectors and edge masks
// ---------------------------------------------------------------------------
//
// channel   dir   handshake                  payload
// s_*       in    s_tvalid / s_tready        s_tdata: buttons, stick x, stick y, tick
// m_*       out   m_tvalid / m_tready        m_tdata: ring entry, m_tuser: wrapped
// cfg_*     in    cfg_valid / cfg_ready      cfg_data: stick threshold square
//
// one item per cycle sustained while m_tready is high; a taken item enters the
// queue, moves to the output register when popped and leaves from there on m_tready
// with m_tready low the queue takes two more items behind the waiting result,
// then s_tready drops until the output register is freed
// reset clears ring slot, previous pad word and both wrap ticks; threshold is 1600
// no clearing pass after reset, items are taken at once
//
`default_nettype none

module pad_state_ring_writer_unit
#(
    parameter int RING_ENTRIES = prs_pkg::RING_ENTRIES_DEFAULT
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // [14:0] button_bits, [23:15] stick_x, [32:24] stick_y, [95:33] tick_now
    input  wire logic [prs_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,

    // [2:0] slot_index, [34:3] pad_word, [66:35] pressed_mask,
    // [98:67] released_mask, [107:99] stick_x_out, [116:108] stick_y_out,
    // [179:117] wrap_tick, [242:180] wrap_tick_before, [247:243] zero
    output logic [prs_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // [0] wrapped
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,

    // stick_threshold_square
    input  wire logic [prs_pkg::THR_W-1:0]        cfg_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready
);

    logic [prs_pkg::THR_W-1:0] threshold_reg;
    logic [prs_pkg::THR_W-1:0] threshold_next;

    prs_pkg::prs_entry_t       push_entry;
    prs_pkg::prs_entry_t       head_entry;
    prs_pkg::prs_q_status_t    q_status;
    logic                      push;
    logic                      pop;

    // config register, always writable
    assign cfg_ready      = 1'b1;
    assign threshold_next = (cfg_valid && cfg_ready) ? cfg_data : threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= prs_pkg::THR_RESET;
        end
        else
        begin
            threshold_reg <= threshold_next;
        end
    end

    // front: accept, unpack, square the stick
    prs_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue decouples the two sides
    prs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // back: sectors, masks, ring state, output register
    prs_back
    #(
        .RING_ENTRIES (RING_ENTRIES)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (threshold_reg),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
